// File: src/tot_pkg.sv
`default_nettype none
package tot_pkg;

  localparam int N_WIDTH = 32;
  localparam int CAND_W  = N_WIDTH / 2 + 1;
  localparam int CNT_W   = $clog2(N_WIDTH);
  localparam int STEP_W  = 4;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE       = STEP_W'(0);
  localparam step_t ST_TRY        = STEP_W'(1);
  localparam step_t ST_TRY_WAIT   = STEP_W'(2);
  localparam step_t ST_TEST       = STEP_W'(3);
  localparam step_t ST_STRIP      = STEP_W'(4);
  localparam step_t ST_STRIP_DIV  = STEP_W'(5);
  localparam step_t ST_STRIP_WAIT = STEP_W'(6);
  localparam step_t ST_RED_DIV    = STEP_W'(7);
  localparam step_t ST_RED_WAIT   = STEP_W'(8);
  localparam step_t ST_NEXT       = STEP_W'(9);
  localparam step_t ST_TAIL       = STEP_W'(10);
  localparam step_t ST_TAIL_DIV   = STEP_W'(11);
  localparam step_t ST_TAIL_WAIT  = STEP_W'(12);
  localparam step_t ST_DONE       = STEP_W'(13);

  typedef enum logic {A_REM, A_ACC} asel_t;
  typedef enum logic {B_CAND, B_REM} bsel_t;
  typedef enum logic [1:0] {W_NONE, W_DIV, W_IN, W_OUT} wait_t;
  typedef enum logic [2:0] {
    WR_NONE, WR_LOAD, WR_REM_Q, WR_ACC_SUB, WR_CAND_INC, WR_OUT
  } wr_t;
  typedef enum logic [2:0] {
    C_NEXT, C_JUMP, C_Q_LT_CAND, C_R_NZ, C_R_Z, C_REM_LE1
  } cond_t;

  typedef struct packed {
    logic  div_start;
    asel_t a_sel;
    bsel_t b_sel;
    wait_t wt;
    wr_t   wr;
    cond_t cond;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic div_busy;
    logic in_valid;
    logic out_free;
    logic q_lt_cand;
    logic r_nz;
    logic rem_le1;
  } flags_t;

  function automatic ctl_t mk(input logic s, input asel_t a, input bsel_t b,
                              input wait_t w, input wr_t r, input cond_t c,
                              input step_t t);
    ctl_t x;
    x.div_start = s;
    x.a_sel     = a;
    x.b_sel     = b;
    x.wt        = w;
    x.wr        = r;
    x.cond      = c;
    x.target    = t;
    return x;
  endfunction

  // microprogram
  function automatic ctl_t prog(input step_t st);
    ctl_t w;
    case (st)
      ST_IDLE:       w = mk(1'b0, A_REM, B_CAND, W_IN,   WR_LOAD,     C_NEXT,      ST_IDLE);
      ST_TRY:        w = mk(1'b1, A_REM, B_CAND, W_NONE, WR_NONE,     C_NEXT,      ST_IDLE);
      ST_TRY_WAIT:   w = mk(1'b0, A_REM, B_CAND, W_DIV,  WR_NONE,     C_Q_LT_CAND, ST_TAIL);
      ST_TEST:       w = mk(1'b0, A_REM, B_CAND, W_NONE, WR_NONE,     C_R_NZ,      ST_NEXT);
      ST_STRIP:      w = mk(1'b0, A_REM, B_CAND, W_NONE, WR_REM_Q,    C_NEXT,      ST_IDLE);
      ST_STRIP_DIV:  w = mk(1'b1, A_REM, B_CAND, W_NONE, WR_NONE,     C_NEXT,      ST_IDLE);
      ST_STRIP_WAIT: w = mk(1'b0, A_REM, B_CAND, W_DIV,  WR_NONE,     C_R_Z,       ST_STRIP);
      ST_RED_DIV:    w = mk(1'b1, A_ACC, B_CAND, W_NONE, WR_NONE,     C_NEXT,      ST_IDLE);
      ST_RED_WAIT:   w = mk(1'b0, A_ACC, B_CAND, W_DIV,  WR_ACC_SUB,  C_NEXT,      ST_IDLE);
      ST_NEXT:       w = mk(1'b0, A_REM, B_CAND, W_NONE, WR_CAND_INC, C_JUMP,      ST_TRY);
      ST_TAIL:       w = mk(1'b0, A_REM, B_CAND, W_NONE, WR_NONE,     C_REM_LE1,   ST_DONE);
      ST_TAIL_DIV:   w = mk(1'b1, A_ACC, B_REM,  W_NONE, WR_NONE,     C_NEXT,      ST_IDLE);
      ST_TAIL_WAIT:  w = mk(1'b0, A_ACC, B_REM,  W_DIV,  WR_ACC_SUB,  C_NEXT,      ST_IDLE);
      ST_DONE:       w = mk(1'b0, A_REM, B_CAND, W_OUT,  WR_OUT,      C_JUMP,      ST_IDLE);
      default:       w = mk(1'b0, A_REM, B_CAND, W_NONE, WR_NONE,     C_JUMP,      ST_IDLE);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: src/totient_trial_division.sv
// Euler totient phi(n) of a 32-bit unsigned request, by trial division run from a
// small microprogram over one shared bit-serial divider. Each candidate p costs one
// trial division, plus further divisions to strip p and reduce the totient when p
// divides the remainder. The run is far shorter for small or highly composite n.
// One request is in flight at a time; a finished result sits in the output register
// while the next request is taken. A zero request returns 0 with bad_input set.
`default_nettype none
module totient_trial_division (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tot_pkg::N_WIDTH-1:0] number_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [tot_pkg::N_WIDTH-1:0] totient,
  output logic                             bad_input
);
  import tot_pkg::*;

  logic [N_WIDTH-1:0] acc;
  logic [N_WIDTH-1:0] rem;
  logic [CAND_W-1:0]  cand;
  logic               bad;

  ctl_t               ctl;
  logic               go;
  flags_t             flags;

  logic               div_start;
  logic               div_busy;
  logic [N_WIDTH-1:0] div_a;
  logic [N_WIDTH-1:0] div_b;
  logic [N_WIDTH-1:0] div_q;
  logic [N_WIDTH-1:0] div_r;
  logic [N_WIDTH-1:0] cand_ext;
  logic               out_free;

  assign cand_ext  = {{(N_WIDTH-CAND_W){1'b0}}, cand};
  assign div_a     = (ctl.a_sel == A_ACC) ? acc : rem;
  assign div_b     = (ctl.b_sel == B_REM) ? rem : cand_ext;
  assign div_start = go && ctl.div_start;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (ctl.wt != W_IN);

  assign flags.div_busy  = div_busy;
  assign flags.in_valid  = in_valid;
  assign flags.out_free  = out_free;
  assign flags.q_lt_cand = div_q < cand_ext;
  assign flags.r_nz      = |div_r;
  assign flags.rem_le1   = (rem[N_WIDTH-1:1] == '0);

  tot_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl),
    .go    (go)
  );

  tot_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quo      (div_q),
    .rmd      (div_r)
  );

  always_ff @(posedge clk) begin
    if (go) begin
      case (ctl.wr)
        WR_LOAD: begin
          acc  <= number_in;
          rem  <= number_in;
          cand <= CAND_W'(2);
          bad  <= (number_in == '0);
        end
        WR_REM_Q:    rem  <= div_q;
        WR_ACC_SUB:  acc  <= acc - div_q;
        WR_CAND_INC: cand <= cand + CAND_W'(1);
        WR_OUT: begin
          totient   <= acc;
          bad_input <= bad;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && ctl.wr == WR_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_acc_no_wrap: assert property (@(posedge clk) disable iff (rst)
    (go && ctl.wr == WR_ACC_SUB) |-> (div_q <= acc))
    else $error("totient reduction would wrap");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_input) |-> (totient == '0))
    else $error("zero request gave nonzero totient");

  a_in_only_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (rem == $past(number_in)))
    else $error("request not loaded");
`endif

endmodule
`default_nettype wire

// File: src/tot_div.sv
`default_nettype none
module tot_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [tot_pkg::N_WIDTH-1:0] dividend,
  input  wire logic [tot_pkg::N_WIDTH-1:0] divisor,
  output logic                             busy,
  output logic      [tot_pkg::N_WIDTH-1:0] quo,
  output logic      [tot_pkg::N_WIDTH-1:0] rmd
);
  import tot_pkg::*;

  logic [N_WIDTH-1:0] dvs;
  logic [CNT_W-1:0]   cnt;
  logic [N_WIDTH:0]   sh;
  logic [N_WIDTH:0]   diff;

  // restoring, one quotient bit per cycle
  assign sh   = {rmd, quo[N_WIDTH-1]};
  assign diff = sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rmd <= '0;
      dvs <= divisor;
      cnt <= CNT_W'(N_WIDTH - 1);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (!diff[N_WIDTH]) begin
        rmd <= diff[N_WIDTH-1:0];
        quo <= {quo[N_WIDTH-2:0], 1'b1};
      end else begin
        rmd <= sh[N_WIDTH-1:0];
        quo <= {quo[N_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// File: src/tot_seq.sv
`default_nettype none
module tot_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tot_pkg::flags_t flags,
  output tot_pkg::ctl_t        ctl,
  output logic                 go
);
  import tot_pkg::*;

  step_t step;
  step_t step_next;
  logic  held;
  logic  taken;

  assign ctl = prog(step);

  always_comb begin
    case (ctl.wt)
      W_DIV:   held = flags.div_busy;
      W_IN:    held = !flags.in_valid;
      W_OUT:   held = !flags.out_free;
      default: held = 1'b0;
    endcase
  end

  assign go = !held;

  always_comb begin
    case (ctl.cond)
      C_JUMP:      taken = 1'b1;
      C_Q_LT_CAND: taken = flags.q_lt_cand;
      C_R_NZ:      taken = flags.r_nz;
      C_R_Z:       taken = !flags.r_nz;
      C_REM_LE1:   taken = flags.rem_le1;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    if (held) begin
      step_next = step;
    end else if (taken) begin
      step_next = ctl.target;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

// File: dv/totient_trial_division_tb.sv
module totient_trial_division_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tot_pkg::N_WIDTH;

  typedef logic [N_WIDTH-1:0] num_t;

  typedef struct {
    num_t value;
    bit   pinned;
    num_t tot;
    logic bad;
  } stim_row_t;

  typedef struct {
    num_t value;
    num_t tot;
    logic bad;
  } phi_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  num_t number_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  num_t totient;
  logic bad_input;

  bit   pin_on = 1'b0;
  num_t pin_tot = '0;
  logic pin_bad = 1'b0;
  bit   quiet = 1'b0;

  phi_t      phi_pending[$];
  stim_row_t plan[$];
  int        n_taken = 0;
  int        n_checked = 0;
  int        n_zero = 0;
  int        n_errors = 0;

  totient_trial_division DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .number_in (number_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .totient   (totient),
    .bad_input (bad_input)
  );

  always #10 clk = ~clk;

  // trial division, 64-bit so the bound test never overflows
  function automatic num_t phi_of(input num_t n);
    longint unsigned acc;
    longint unsigned rest;
    longint unsigned p;
    acc  = n;
    rest = n;
    for (p = 2; p <= rest / p; p++) begin
      if (rest % p == 0) begin
        while (rest % p == 0) rest = rest / p;
        acc = acc - acc / p;
      end
    end
    if (rest > 1) acc = acc - acc / rest;
    return num_t'(acc);
  endfunction

  function automatic stim_row_t row(input num_t v, input bit pinned, input num_t t,
                                    input logic b);
    stim_row_t r;
    r.value  = v;
    r.pinned = pinned;
    r.tot    = t;
    r.bad    = b;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(9);
    if (quiet) return 0;
    if (r < 6) return $urandom_range(2);
    if (r < 9) return $urandom_range(8, 3);
    return $urandom_range(60, 20);
  endfunction

  // mostly cheap values; large ones are a small value shifted up or times 65537, so trial division ends early
  function automatic num_t pick_number();
    int   r;
    num_t m;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 55) return num_t'($urandom_range(4095));
    if (r < 85) begin
      m = num_t'($urandom_range(65535, 1));
      return m << $urandom_range(16);
    end
    if (r < 93) return num_t'($urandom_range(262143));
    m = num_t'($urandom_range(256, 1));
    return m * 65537;
  endfunction

  always @(posedge clk) begin : scoreboard
    phi_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want.value = number_in;
        if (pin_on) begin
          want.tot = pin_tot;
          want.bad = pin_bad;
        end else if (number_in == '0) begin
          want.tot = '0;
          want.bad = 1'b1;
        end else begin
          want.tot = phi_of(number_in);
          want.bad = 1'b0;
        end
        if (number_in == '0) n_zero++;
        phi_pending.push_back(want);
        n_taken++;
      end
      if (out_valid && !out_stall) begin
        if (phi_pending.size() == 0) begin
          $display("%0t: result with no request pending: totient %h bad_input %b",
                   $time, totient, bad_input);
          n_errors++;
        end else begin
          want = phi_pending.pop_front();
          if (totient !== want.tot) begin
            $display("%0t: totient of %h: expected %h, actual %h",
                     $time, want.value, want.tot, totient);
            n_errors++;
          end
          if (bad_input !== want.bad) begin
            $display("%0t: bad_input for %h: expected %b, actual %b",
                     $time, want.value, want.bad, bad_input);
            n_errors++;
          end
          n_checked++;
        end
      end
    end
  end

  initial begin : result_side
    int hold;
    int run;
    @(negedge rst);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        hold = pick_gap();
        run  = $urandom_range(12, 1);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : request_side
    int   gap;
    int   k;
    num_t v;

    plan.push_back(row(32'h0000_0000, 1, 32'h0000_0000, 1'b1));
    plan.push_back(row(32'h0000_0001, 1, 32'h0000_0001, 1'b0));
    plan.push_back(row(32'h0000_0002, 1, 32'h0000_0001, 1'b0));
    plan.push_back(row(32'h0000_0003, 0, '0, 1'b0));
    plan.push_back(row(32'h0000_0004, 0, '0, 1'b0));
    plan.push_back(row(32'h0000_0000, 1, 32'h0000_0000, 1'b1));
    plan.push_back(row(32'h0000_0006, 0, '0, 1'b0));
    plan.push_back(row(32'd12, 0, '0, 1'b0));
    plan.push_back(row(32'd30, 0, '0, 1'b0));
    plan.push_back(row(32'd36, 0, '0, 1'b0));
    plan.push_back(row(32'd97, 0, '0, 1'b0));
    plan.push_back(row(32'd63001, 0, '0, 1'b0));
    plan.push_back(row(32'd65536, 1, 32'd32768, 1'b0));
    plan.push_back(row(32'd65537, 1, 32'd65536, 1'b0));
    plan.push_back(row(32'd131074, 0, '0, 1'b0));
    plan.push_back(row(32'd1000000, 0, '0, 1'b0));
    plan.push_back(row(32'd9699690, 0, '0, 1'b0));
    plan.push_back(row(32'h8000_0000, 1, 32'h4000_0000, 1'b0));
    plan.push_back(row(32'hFFFF_FFFF, 1, 32'h8000_0000, 1'b0));
    plan.push_back(row(32'hAAAA_AAAA, 0, '0, 1'b0));
    plan.push_back(row(32'h5555_5555, 0, '0, 1'b0));
    plan.push_back(row(32'hFFFF_0000, 0, '0, 1'b0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < 100; k++) begin
      quiet = ((k / 16) % 3 == 1);
      if (k < plan.size()) begin
        v = plan[k].value;
      end else begin
        v = pick_number();
      end
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid  <= 1'b1;
      number_in <= v;
      if (k < plan.size()) begin
        pin_on  <= plan[k].pinned;
        pin_tot <= plan[k].tot;
        pin_bad <= plan[k].bad;
      end else begin
        pin_on <= 1'b0;
      end
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (phi_pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d requests (%0d directed, %0d zero) and checked %0d totients,",
             n_taken, plan.size(), n_zero, n_checked);
    $display("with random request gaps and result stalls; %0d mismatches.", n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
src/tot_pkg.sv
src/tot_div.sv
src/tot_seq.sv
src/totient_trial_division.sv
dv/totient_trial_division_tb.sv
